// File: rtl/pws_pkg.sv
// Shared types and constants of the pulse-width spectrum unit.
// Holds the request codes, register indexes, FSM states and the
// command/status structs between controller and datapath. No dependencies.
package pws_pkg;

  localparam int SPEC_BINS   = 100;
  localparam int HIST_DEPTH  = 100;
  localparam int SPEC_AW     = $clog2(SPEC_BINS);
  localparam int HIST_AW     = $clog2(HIST_DEPTH);
  localparam int IDX_W       = 7;
  localparam int HSUM_W      = ((HIST_AW > IDX_W) ? HIST_AW : IDX_W) + 1;
  localparam int CNT_W       = 32;
  localparam int TIME_W      = 16;
  localparam int WID_W       = TIME_W + 2;
  localparam int CFG_IW      = 2;
  localparam int CFG_DW      = 16;

  typedef enum logic [1:0] {
    REQ_CAPTURE = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_RD_SPEC = 2'd2,
    REQ_RD_HIST = 2'd3
  } req_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_WIDTH_OFFSET = 2'd0,
    CFG_BIN_DIVISOR  = 2'd1,
    CFG_HOLD_HISTORY = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RATE_INC,
    S_OFFSET,
    S_DIV,
    S_SPEC_INC,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;          // latch the accepted item, clear the result
    logic open_set;      // open a pulse at the latched capture
    logic open_clr;
    logic width_calc;    // register the raw width of the closing pulse
    logic rate_rd;
    logic rate_rd_head;  // read address is the current-second entry
    logic rate_inc;
    logic tick;
    logic div_start;
    logic spec_rd;
    logic spec_rd_q;     // read address is the quotient
    logic spec_inc;
    logic rd_capture;    // take the read value into the result
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    req_t req;
    logic pin;
    logic open;
    logic hold;
    logic spec_idx_ok;
    logic hist_idx_ok;
    logic discard;
    logic div_done;
    logic q_ok;
  } dp_status_t;

endpackage

// File: rtl/pws_divider.sv
// Restoring divider for the pulse-width spectrum unit, one quotient bit a cycle.
// Depends on pws_pkg for the operand width.
module pws_divider import pws_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic [TIME_W-1:0] quotient,
  output logic              done
);

  localparam int STEP_W = $clog2(TIME_W + 1);

  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [TIME_W-1:0] quo_r, quo_nxt;
  logic [TIME_W-1:0] div_r, div_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [TIME_W:0]   shifted;
  logic [TIME_W+1:0] diff;

  assign shifted = {rem_r, quo_r[TIME_W-1]};
  assign diff    = {1'b0, shifted} - (TIME_W+2)'(div_r);

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      // a zero divisor acts as one
      div_nxt  = (divisor == '0) ? TIME_W'(1) : divisor;
      cnt_nxt  = STEP_W'(TIME_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[TIME_W+1]) begin
        rem_nxt = diff[TIME_W-1:0];
        quo_nxt = {quo_r[TIME_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[TIME_W-1:0];
        quo_nxt = {quo_r[TIME_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// File: rtl/pws_datapath.sv
// Datapath of the pulse-width spectrum unit: config registers, pulse state,
// spectrum and rate-history memories, width arithmetic and result registers.
// Depends on pws_pkg and pws_divider.
module pws_datapath import pws_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic [1:0]        in_req_type,
  input  logic [TIME_W-1:0] in_capture_value,
  input  logic              in_pin_level,
  input  logic [IDX_W-1:0]  in_read_index,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        st,
  output logic [CNT_W-1:0]  out_read_data,
  output logic              out_bin_hit,
  output logic              out_pulse_open
);

  // configuration
  logic [TIME_W-1:0] width_offset_r;
  logic [TIME_W-1:0] bin_divisor_r;
  logic              hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_offset_r <= '0;
      bin_divisor_r  <= TIME_W'(1);
      hold_r         <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH_OFFSET: width_offset_r <= cfg_data[TIME_W-1:0];
        CFG_BIN_DIVISOR:  bin_divisor_r  <= cfg_data[TIME_W-1:0];
        CFG_HOLD_HISTORY: hold_r         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // latched item
  req_t              req_r;
  logic [TIME_W-1:0] cap_r;
  logic              pin_r;
  logic [IDX_W-1:0]  idx_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req_t'(in_req_type);
      cap_r <= in_capture_value;
      pin_r <= in_pin_level;
      idx_r <= in_read_index;
    end
  end

  // pulse state and history ring head
  logic              open_r;
  logic [TIME_W-1:0] start_r;
  logic [HIST_AW-1:0] head_r, head_dec;

  assign head_dec = (head_r == '0) ? HIST_AW'(HIST_DEPTH - 1) : head_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      start_r <= '0;
      head_r  <= '0;
    end else begin
      if (cmd.open_set) begin
        open_r  <= 1'b1;
        start_r <= cap_r;
      end else if (cmd.open_clr) begin
        open_r <= 1'b0;
      end
      if (cmd.tick) begin
        head_r <= head_dec;
      end
    end
  end

  // raw width with 16-bit wrap; a negative value marks a discarded pulse
  logic [WID_W-1:0] w_calc, w_r, d_calc;

  always_comb begin
    if (cap_r > start_r) begin
      w_calc = WID_W'(cap_r) - WID_W'(start_r) - WID_W'(1);
    end else if (cap_r < start_r) begin
      w_calc = WID_W'({TIME_W{1'b1}}) - WID_W'(start_r) + WID_W'(cap_r) - WID_W'(1);
    end else begin
      w_calc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.width_calc) begin
      w_r <= w_calc;
    end
  end

  assign d_calc = w_r - WID_W'(width_offset_r);

  logic [TIME_W-1:0] quo;
  logic              div_done;

  pws_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (d_calc[TIME_W-1:0]),
    .divisor  (bin_divisor_r),
    .quotient (quo),
    .done     (div_done)
  );

  // spectrum memory, valid bits stand for the cleared state
  logic [CNT_W-1:0]     spec_mem [SPEC_BINS];
  logic [SPEC_BINS-1:0] spec_vld;
  logic [CNT_W-1:0]     spec_rd_data_r, spec_val;
  logic                 spec_rd_vld_r;
  logic [SPEC_AW-1:0]   spec_ra, spec_wa;

  assign spec_wa  = SPEC_AW'(quo);
  assign spec_ra  = cmd.spec_rd_q ? spec_wa : SPEC_AW'(idx_r);
  assign spec_val = spec_rd_vld_r ? spec_rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.spec_inc) begin
      spec_mem[spec_wa] <= spec_val + 1'b1;
    end
    if (cmd.spec_rd) begin
      spec_rd_data_r <= spec_mem[spec_ra];
      spec_rd_vld_r  <= spec_vld[spec_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spec_vld <= '0;
    end else if (cmd.spec_inc) begin
      spec_vld[spec_wa] <= 1'b1;
    end
  end

  // rate history memory, ring addressed from the head
  logic [CNT_W-1:0]      rate_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] rate_vld;
  logic [CNT_W-1:0]      rate_rd_data_r, rate_val, rate_wd;
  logic                  rate_rd_vld_r;
  logic [HIST_AW-1:0]    rate_ra, rate_wa, hist_addr;
  logic [HSUM_W-1:0]     hist_sum;
  logic                  rate_we;

  assign hist_sum  = HSUM_W'(head_r) + HSUM_W'(idx_r);
  assign hist_addr = (int'(hist_sum) >= HIST_DEPTH) ?
                     HIST_AW'(hist_sum - HSUM_W'(HIST_DEPTH)) : HIST_AW'(hist_sum);
  assign rate_ra   = cmd.rate_rd_head ? head_r : hist_addr;
  assign rate_val  = rate_rd_vld_r ? rate_rd_data_r : '0;
  assign rate_we   = cmd.rate_inc | cmd.tick;
  assign rate_wa   = cmd.tick ? head_dec : head_r;
  assign rate_wd   = cmd.tick ? '0 : rate_val + 1'b1;

  always_ff @(posedge clk) begin
    if (rate_we) begin
      rate_mem[rate_wa] <= rate_wd;
    end
    if (cmd.rate_rd) begin
      rate_rd_data_r <= rate_mem[rate_ra];
      rate_rd_vld_r  <= rate_vld[rate_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_vld <= '0;
    end else if (rate_we) begin
      rate_vld[rate_wa] <= 1'b1;
    end
  end

  // result and output registers
  logic [CNT_W-1:0] res_data_r, out_data_r;
  logic             res_hit_r, out_hit_r, out_open_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_data_r <= '0;
      res_hit_r  <= 1'b0;
    end else begin
      if (cmd.rd_capture) begin
        res_data_r <= (req_r == REQ_RD_SPEC) ? spec_val : rate_val;
      end
      if (cmd.spec_inc) begin
        res_hit_r <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_data_r <= res_data_r;
      out_hit_r  <= res_hit_r;
      out_open_r <= open_r;
    end
  end

  assign out_read_data  = out_data_r;
  assign out_bin_hit    = out_hit_r;
  assign out_pulse_open = out_open_r;

  always_comb begin
    st.req         = req_r;
    st.pin         = pin_r;
    st.open        = open_r;
    st.hold        = hold_r;
    st.spec_idx_ok = int'(idx_r) < SPEC_BINS;
    st.hist_idx_ok = int'(idx_r) < HIST_DEPTH;
    st.discard     = w_r[WID_W-1] | d_calc[WID_W-1];
    st.div_done    = div_done;
    st.q_ok        = int'(quo) < SPEC_BINS;
  end

endmodule

// File: rtl/pws_ctrl.sv
// Controller of the pulse-width spectrum unit: sequences one item through
// the datapath and owns the input ready and output valid. Depends on pws_pkg.
module pws_ctrl import pws_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (st.req)
          REQ_CAPTURE: begin
            if (st.open) begin
              cmd.open_clr   = 1'b1;
              cmd.width_calc = 1'b1;
              state_nxt      = S_OFFSET;
            end else if (!st.pin) begin
              cmd.open_set     = 1'b1;
              cmd.rate_rd      = 1'b1;
              cmd.rate_rd_head = 1'b1;
              state_nxt        = S_RATE_INC;
            end
          end
          REQ_TICK: begin
            cmd.tick = !st.hold;
          end
          REQ_RD_SPEC: begin
            if (st.spec_idx_ok) begin
              cmd.spec_rd = 1'b1;
              state_nxt   = S_READ;
            end
          end
          REQ_RD_HIST: begin
            if (st.hist_idx_ok) begin
              cmd.rate_rd = 1'b1;
              state_nxt   = S_READ;
            end
          end
          default: ;
        endcase
      end
      S_RATE_INC: begin
        cmd.rate_inc = 1'b1;
        state_nxt    = S_DONE;
      end
      S_OFFSET: begin
        if (st.discard) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          if (st.q_ok) begin
            cmd.spec_rd   = 1'b1;
            cmd.spec_rd_q = 1'b1;
            state_nxt     = S_SPEC_INC;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SPEC_INC: begin
        cmd.spec_inc = 1'b1;
        state_nxt    = S_DONE;
      end
      S_READ: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/pulse_width_spectrum_unit.sv
// Top level of the pulse-width spectrum unit: controller plus datapath.
// Depends on pws_pkg, pws_ctrl, pws_datapath (and pws_divider below it).
//
//   port group  direction  handshake            payload
//   in_         input      in_valid/in_ready    req_type, capture_value, pin_level, read_index
//   out_        output     out_valid/out_ready  read_data, bin_hit, pulse_open
//   cfg_        input      cfg_we               cfg_index, cfg_data
//
// One item at a time, one result per item. A closing capture runs through S_EXEC, S_OFFSET,
// the 16-step restoring divider in S_DIV and the bin read-modify-write in S_SPEC_INC; an opening
// capture goes through S_RATE_INC and an in-range read through S_READ; a tick, an ignored capture
// or an out-of-range read goes from S_EXEC to S_DONE, a discarded pulse from S_OFFSET to S_DONE.
// Reset clears both memories at once through per-entry valid bits.
// A result waits in the output register while the next item is accepted.
module pulse_width_spectrum_unit import pws_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [TIME_W-1:0] in_capture_value,
  input  logic              in_pin_level,
  input  logic [IDX_W-1:0]  in_read_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CNT_W-1:0]  out_read_data,
  output logic              out_bin_hit,
  output logic              out_pulse_open
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  pws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  pws_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_req_type      (in_req_type),
    .in_capture_value (in_capture_value),
    .in_pin_level     (in_pin_level),
    .in_read_index    (in_read_index),
    .cmd              (cmd),
    .st               (st),
    .out_read_data    (out_read_data),
    .out_bin_hit      (out_bin_hit),
    .out_pulse_open   (out_pulse_open)
  );

`ifndef SYNTHESIS
  // an accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accepted item");

  // a bin hit only comes from a closing capture
  a_hit_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bin_hit |-> !out_pulse_open && out_read_data == '0)
    else $error("bin hit with open pulse or read data");

  // the spectrum is only written after a finished division
  a_inc_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.spec_inc |-> $past(st.div_done))
    else $error("spectrum increment without a division result");
`endif

endmodule

// File: verif/tb_pulse_width_spectrum_unit.sv
`timescale 1ns / 100ps
// Testbench of pulse_width_spectrum_unit: directed and random captures, ticks and reads,
// checked item by item against an untimed predictor of the spectrum bins and rate history.
// Depends on pws_pkg and the unit's RTL.
module tb_pulse_width_spectrum_unit;
  import pws_pkg::*;

  localparam int IDLE_LIMIT      = 3000;
  localparam int SETTLE_CYCLES   = 25;
  localparam int ITEMS_PER_PHASE = 150;

  typedef struct packed {
    logic [CNT_W-1:0] read_data;
    logic             bin_hit;
    logic             pulse_open;
  } pws_result_t;

  class pws_scoreboard;
    logic [TIME_W-1:0] width_offset;
    logic [TIME_W-1:0] bin_divisor;
    logic              hold_history;
    logic              open_flag;
    logic [TIME_W-1:0] start_time;
    logic [CNT_W-1:0]  spectrum [SPEC_BINS];
    logic [CNT_W-1:0]  rate_hist [HIST_DEPTH];
    int                head;
    pws_result_t       expected_q [$];
    int                errors;

    function new();
      width_offset = '0;
      bin_divisor  = TIME_W'(1);
      hold_history = 1'b0;
      open_flag    = 1'b0;
      start_time   = '0;
      head         = 0;
      errors       = 0;
      foreach (spectrum[i]) spectrum[i] = '0;
      foreach (rate_hist[i]) rate_hist[i] = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DW-1:0] value);
      case (idx)
        CFG_WIDTH_OFFSET: width_offset = value;
        CFG_BIN_DIVISOR:  bin_divisor = value;
        CFG_HOLD_HISTORY: hold_history = value[0];
        default: ;
      endcase
    endfunction

    // Bin a closing capture; return 1 when a spectrum bin was counted.
    function logic close_pulse(logic [TIME_W-1:0] stop);
      int w;
      int q;
      int div;
      div = (bin_divisor == 0) ? 1 : int'(bin_divisor);
      if (stop > start_time) w = int'(stop) - int'(start_time) - 1;
      else if (stop < start_time) w = 32'hFFFF - int'(start_time) + int'(stop) - 1;
      else w = 0;
      if (w < 0) return 1'b0;
      w = w - int'(width_offset);
      if (w < 0) return 1'b0;
      q = w / div;
      if (q >= SPEC_BINS) return 1'b0;
      spectrum[q] = spectrum[q] + 1;
      return 1'b1;
    endfunction

    function void note_item(req_t req, logic [TIME_W-1:0] cap, logic pin,
                            logic [IDX_W-1:0] idx);
      pws_result_t r;
      r = '0;
      case (req)
        REQ_CAPTURE: begin
          if (!open_flag) begin
            if (!pin) begin
              open_flag       = 1'b1;
              start_time      = cap;
              rate_hist[head] = rate_hist[head] + 1;
            end
          end else begin
            open_flag = 1'b0;
            r.bin_hit = close_pulse(cap);
          end
        end
        REQ_TICK: begin
          // age the ring: the new current-second entry starts from zero
          if (!hold_history) begin
            head            = (head + HIST_DEPTH - 1) % HIST_DEPTH;
            rate_hist[head] = '0;
          end
        end
        REQ_RD_SPEC: begin
          if (idx < SPEC_BINS) r.read_data = spectrum[idx];
        end
        default: begin
          if (idx < HIST_DEPTH) r.read_data = rate_hist[(head + idx) % HIST_DEPTH];
        end
      endcase
      r.pulse_open = open_flag;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("%0t: %s", $time, msg);
    endtask

    task check_result(pws_result_t got);
      pws_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no item pending, read_data 0x%0h", got.read_data));
        return;
      end
      want = expected_q.pop_front();
      if (got.read_data !== want.read_data)
        report($sformatf("read_data 0x%0h, expected 0x%0h", got.read_data, want.read_data));
      if (got.bin_hit !== want.bin_hit)
        report($sformatf("bin_hit %b, expected %b", got.bin_hit, want.bin_hit));
      if (got.pulse_open !== want.pulse_open)
        report($sformatf("pulse_open %b, expected %b", got.pulse_open, want.pulse_open));
    endtask
  endclass

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              cfg_we           = 1'b0;
  logic [CFG_IW-1:0] cfg_index        = '0;
  logic [CFG_DW-1:0] cfg_data         = '0;
  logic              in_valid         = 1'b0;
  logic              in_ready;
  logic [1:0]        in_req_type      = '0;
  logic [TIME_W-1:0] in_capture_value = '0;
  logic              in_pin_level     = 1'b0;
  logic [IDX_W-1:0]  in_read_index    = '0;
  logic              out_valid;
  logic              out_ready        = 1'b0;
  logic [CNT_W-1:0]  out_read_data;
  logic              out_bin_hit;
  logic              out_pulse_open;

  pws_scoreboard sb;
  bit            calm = 1'b0;
  int            idle_cycles = 0;

  pulse_width_spectrum_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_capture_value (in_capture_value),
    .in_pin_level     (in_pin_level),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_bin_hit      (out_bin_hit),
    .out_pulse_open   (out_pulse_open)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones, none during calm stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(req_t req, logic [TIME_W-1:0] cap, logic pin,
                           logic [IDX_W-1:0] idx);
    int gap;
    @(negedge clk);
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_capture_value <= cap;
    in_pin_level     <= pin;
    in_read_index    <= idx;
    do @(posedge clk); while (!in_ready);
    sb.note_item(req, cap, pin, idx);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_pulse(logic [TIME_W-1:0] t_open, logic [TIME_W-1:0] t_close,
                            logic close_pin);
    send_item(REQ_CAPTURE, t_open, 1'b0, IDX_W'($urandom_range(0, 127)));
    send_item(REQ_CAPTURE, t_close, close_pin, IDX_W'($urandom_range(0, 127)));
  endtask

  // Drop valid, wait for every pending result, then let the block go quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(logic [CFG_DW-1:0] offset, logic [CFG_DW-1:0] divisor,
                           logic hold);
    settle();
    write_reg(CFG_WIDTH_OFFSET, offset);
    write_reg(CFG_BIN_DIVISOR, divisor);
    write_reg(CFG_HOLD_HISTORY, {{(CFG_DW-1){1'b0}}, hold});
  endtask

  task automatic run_random(int count);
    int                n;
    int                pick;
    longint            span;
    logic [TIME_W-1:0] t0;
    logic [IDX_W-1:0]  idx;
    n = 0;
    while (n < count) begin
      calm = (n % 100) >= 70;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // well-formed pulse, width aimed mostly at the spectrum range
        t0 = TIME_W'($urandom());
        if ($urandom_range(0, 4) != 0)
          span = longint'(sb.width_offset)
               + longint'($urandom_range(0, 104)) * longint'(sb.bin_divisor)
               + longint'($urandom_range(0, sb.bin_divisor - 1));
        else
          span = longint'($urandom_range(0, 65535));
        if (span > 65533) span = longint'($urandom_range(0, 65533));
        send_pulse(t0, t0 + span[TIME_W-1:0] + 1'b1, 1'($urandom_range(0, 1)));
        n += 2;
      end else begin
        if (pick < 60) begin
          send_item(REQ_TICK, TIME_W'($urandom()), 1'($urandom_range(0, 1)),
                    IDX_W'($urandom_range(0, 127)));
        end else if (pick < 75) begin
          if ($urandom_range(0, 9) != 0) idx = IDX_W'($urandom_range(0, 99));
          else idx = IDX_W'($urandom_range(100, 127));
          send_item(REQ_RD_SPEC, TIME_W'($urandom()), 1'($urandom_range(0, 1)), idx);
        end else if (pick < 90) begin
          if ($urandom_range(0, 2) != 0) idx = IDX_W'($urandom_range(0, 15));
          else idx = IDX_W'($urandom_range(0, 127));
          send_item(REQ_RD_HIST, TIME_W'($urandom()), 1'($urandom_range(0, 1)), idx);
        end else begin
          send_item(REQ_CAPTURE, TIME_W'($urandom()), 1'($urandom_range(0, 1)),
                    IDX_W'($urandom_range(0, 127)));
        end
        n++;
      end
    end
    calm = 1'b0;
  endtask

  initial begin : receiver
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_read_data, out_bin_hit, out_pulse_open});
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings.
    send_item(REQ_RD_SPEC, 16'h0000, 1'b0, 7'd0);
    send_item(REQ_RD_SPEC, 16'hFFFF, 1'b1, 7'd127);
    send_item(REQ_RD_HIST, 16'h0000, 1'b0, 7'd0);
    send_item(REQ_RD_HIST, 16'hFFFF, 1'b1, 7'd100);
    send_item(REQ_CAPTURE, 16'h1234, 1'b1, 7'd0);     // pin high, nothing open: ignored
    send_pulse(16'hFFFF, 16'h0000, 1'b0);              // negative width
    send_pulse(16'h0000, 16'hFFFF, 1'b0);              // widest pulse, past the last bin
    send_pulse(16'd5, 16'd5, 1'b0);                    // equal captures, bin 0
    send_pulse(16'd10, 16'd110, 1'b1);                 // last bin
    send_pulse(16'd10, 16'd111, 1'b0);                 // one past the last bin
    send_pulse(16'hFFF0, 16'h0005, 1'b0);              // timer wrap
    send_item(REQ_CAPTURE, 16'd200, 1'b0, 7'd0);       // tick while a pulse is open
    send_item(REQ_TICK, 16'd0, 1'b0, 7'd0);
    send_item(REQ_CAPTURE, 16'd210, 1'b1, 7'd0);
    send_item(REQ_RD_SPEC, 16'd0, 1'b0, 7'd19);
    send_item(REQ_RD_SPEC, 16'd0, 1'b0, 7'd99);
    send_item(REQ_RD_HIST, 16'd0, 1'b0, 7'd0);
    send_item(REQ_RD_HIST, 16'd0, 1'b0, 7'd1);
    send_item(REQ_RD_HIST, 16'd0, 1'b0, 7'd99);

    configure(16'd0, 16'd1, 1'b0);
    run_random(ITEMS_PER_PHASE);
    configure(16'd1000, 16'd37, 1'b1);
    run_random(ITEMS_PER_PHASE / 2);
    settle();
    run_random(ITEMS_PER_PHASE / 2);
    configure(16'hFFFF, 16'hFFFF, 1'b0);
    run_random(ITEMS_PER_PHASE);
    configure(16'd3, 16'hFFFF, 1'b1);
    run_random(ITEMS_PER_PHASE);
    configure(16'd20, 16'd5, 1'b0);
    run_random(ITEMS_PER_PHASE);
    configure(16'd0, 16'd1, 1'b0);
    run_random(ITEMS_PER_PHASE);
    settle();

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
